FILE: rtl/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

    // Width of every quaternion and point component on the ports.
    localparam int COMP_WIDTH = 16;

    // Default number of fraction bits of the rotation quaternion.
    localparam int QUAT_FRAC_BITS_DFLT = 14;

    typedef struct packed {
        logic                         action;
        logic signed [COMP_WIDTH-1:0] quat_w;
        logic signed [COMP_WIDTH-1:0] quat_x;
        logic signed [COMP_WIDTH-1:0] quat_y;
        logic signed [COMP_WIDTH-1:0] quat_z;
        logic signed [COMP_WIDTH-1:0] point_x;
        logic signed [COMP_WIDTH-1:0] point_y;
        logic signed [COMP_WIDTH-1:0] point_z;
        logic signed [COMP_WIDTH-1:0] point_w;
    } t_qvr_cmd;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] out_x;
        logic signed [COMP_WIDTH-1:0] out_y;
        logic signed [COMP_WIDTH-1:0] out_z;
        logic signed [COMP_WIDTH-1:0] out_w;
        logic                         clipped;
    } t_qvr_res;

endpackage

`default_nettype wire

FILE: rtl/qvr_mul_stage.sv
`default_nettype none

// All sixteen component products of two quaternions, one register stage.
// Index order of both operands is x, y, z, w.
module qvr_mul_stage #(
    parameter int AW = 17,
    parameter int BW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [AW-1:0]    i_l [4],
    input  logic signed [BW-1:0]    i_r [4],
    output logic                    o_valid,
    output logic signed [AW+BW-1:0] o_prod [4][4]
);

    localparam int PW = AW + BW;

    logic                 r_valid;
    logic signed [PW-1:0] r_prod [4][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= i_l[i] * i_r[j];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

FILE: rtl/qvr_sum_stage.sv
`default_nettype none

// Signed sums of a Hamilton product, rounded half up, shifted right by QF and
// saturated to OW bits when wider, else sign-extended, one register stage.
module qvr_sum_stage #(
    parameter int PW = 33,
    parameter int QF = 14,
    parameter int OW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [PW-1:0] i_prod [4][4],
    output logic                 o_valid,
    output logic signed [OW-1:0] o_q [4],
    output logic                 o_clip
);

    localparam int EW = PW + 2;
    localparam int SW = EW - QF;
    localparam logic signed [EW-1:0] HALF = {{(EW-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};

    logic signed [EW-1:0] e   [4][4];
    logic signed [EW-1:0] s   [4];
    logic signed [EW-1:0] rnd [4];
    logic signed [SW-1:0] sh  [4];
    logic signed [OW-1:0] n_q [4];
    logic                 n_clip;

    logic                 r_valid;
    logic signed [OW-1:0] r_q [4];
    logic                 r_clip;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                e[i][j] = {{2{i_prod[i][j][PW-1]}}, i_prod[i][j]};
            end
        end
        s[0] =  e[0][3] + e[1][2] - e[2][1] + e[3][0];
        s[1] = -e[0][2] + e[1][3] + e[2][0] + e[3][1];
        s[2] =  e[0][1] - e[1][0] + e[2][3] + e[3][2];
        s[3] = -e[0][0] - e[1][1] - e[2][2] + e[3][3];
        for (int k = 0; k < 4; k++) begin
            rnd[k] = s[k] + HALF;
            sh[k]  = rnd[k][EW-1:QF];
        end
    end

    generate
        if (SW > OW) begin : g_clamp
            localparam logic signed [SW-1:0] HI = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
            localparam logic signed [SW-1:0] LO = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};
            always_comb begin
                n_clip = 1'b0;
                for (int k = 0; k < 4; k++) begin
                    if (sh[k] > HI) begin
                        n_q[k] = HI[OW-1:0];
                        n_clip = 1'b1;
                    end else if (sh[k] < LO) begin
                        n_q[k] = LO[OW-1:0];
                        n_clip = 1'b1;
                    end else begin
                        n_q[k] = sh[k][OW-1:0];
                    end
                end
            end
        end else begin : g_extend
            always_comb begin
                n_clip = 1'b0;
                for (int k = 0; k < 4; k++) begin
                    n_q[k] = OW'(sh[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q    <= n_q;
            r_clip <= n_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

FILE: rtl/quaternion_vector_rotation.sv
// A taken transaction is registered in stage 0, then in the multiply and sum stages 1 to 4.
// Throughput: one transaction per cycle when not busy, set by the five-stage multiply/sum pipeline.
// Reset: synchronous, active low; it empties the pipeline and holds busy high
// for the cycle after reset. The receiver cannot stall: o_valid pulses for one
// cycle per result, and results leave in the order their transactions came in.
`default_nettype none

module quaternion_vector_rotation #(
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qvr_pkg::t_qvr_cmd i_cmd,
    output logic              o_valid,
    output qvr_pkg::t_qvr_res o_result
);

    import qvr_pkg::*;

    // Component widths along the datapath. A quaternion operand is carried one
    // bit wider than the port so that its conjugate (negated x, y, z) is exact,
    // including the most negative value.
    localparam int CW  = COMP_WIDTH;
    localparam int QW  = CW + 1;
    localparam int PW1 = QW + CW;
    localparam int SW1 = PW1 + 2 - QUAT_FRAC_BITS;
    // The intermediate quaternion is held to at most 32 bits, saturating.
    localparam int IW  = (SW1 > 32) ? 32 : SW1;
    localparam int PW2 = IW + QW;

    // Stage 0: operand selection. Forward rotation computes (q*p)*conj(q);
    // inverse rotation computes (conj(q)*p)*q. The operand of the second
    // product is formed here and travels alongside the first product.
    logic signed [QW-1:0] q_ext [4];
    logic signed [QW-1:0] q_neg [4];
    logic signed [QW-1:0] n_l1  [4];
    logic signed [QW-1:0] n_q2  [4];
    logic signed [CW-1:0] n_r1  [4];
    logic                 w_accept;

    logic                 r_busy;
    logic                 r_s0_valid;
    logic signed [QW-1:0] r_l1    [4];
    logic signed [CW-1:0] r_r1    [4];
    logic signed [QW-1:0] r_q2_s0 [4];
    logic signed [QW-1:0] r_q2_s1 [4];
    logic signed [QW-1:0] r_q2_s2 [4];

    logic                  m1_valid;
    logic signed [PW1-1:0] m1_prod [4][4];
    logic                  t_valid;
    logic signed [IW-1:0]  t_q [4];
    logic                  t_clip;
    logic                  r_clip_s3;
    logic                  r_clip_s4;
    logic                  m2_valid;
    logic signed [PW2-1:0] m2_prod [4][4];
    logic                  f_valid;
    logic signed [CW-1:0]  f_q [4];
    logic                  f_clip;

    // The pipeline never stalls, so a transaction is taken in every cycle in which
    // start is high, except the one that follows reset.
    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_comb begin
        q_ext[0] = {i_cmd.quat_x[CW-1], i_cmd.quat_x};
        q_ext[1] = {i_cmd.quat_y[CW-1], i_cmd.quat_y};
        q_ext[2] = {i_cmd.quat_z[CW-1], i_cmd.quat_z};
        q_ext[3] = {i_cmd.quat_w[CW-1], i_cmd.quat_w};
        for (int k = 0; k < 4; k++) begin
            q_neg[k] = -q_ext[k];
        end
        for (int k = 0; k < 3; k++) begin
            n_l1[k] = i_cmd.action ? q_neg[k] : q_ext[k];
            n_q2[k] = i_cmd.action ? q_ext[k] : q_neg[k];
        end
        n_l1[3] = q_ext[3];
        n_q2[3] = q_ext[3];
        n_r1[0] = i_cmd.point_x;
        n_r1[1] = i_cmd.point_y;
        n_r1[2] = i_cmd.point_z;
        n_r1[3] = i_cmd.point_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_s0_valid <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_s0_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_l1    <= n_l1;
            r_r1    <= n_r1;
            r_q2_s0 <= n_q2;
        end
    end

    // Stages 1 and 2: first Hamilton product, products then rounded sums.
    qvr_mul_stage #(
        .AW (QW),
        .BW (CW)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_l     (r_l1),
        .i_r     (r_r1),
        .o_valid (m1_valid),
        .o_prod  (m1_prod)
    );

    qvr_sum_stage #(
        .PW (PW1),
        .QF (QUAT_FRAC_BITS),
        .OW (IW)
    ) u_sum1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_valid),
        .i_prod  (m1_prod),
        .o_valid (t_valid),
        .o_q     (t_q),
        .o_clip  (t_clip)
    );

    // The second operand and the first saturation flag are delayed so that
    // they line up with the intermediate quaternion and the final sums.
    always_ff @(posedge i_clk) begin
        r_q2_s1   <= r_q2_s0;
        r_q2_s2   <= r_q2_s1;
        r_clip_s3 <= t_clip;
        r_clip_s4 <= r_clip_s3;
    end

    // Stages 3 and 4: second Hamilton product and the final saturation.
    qvr_mul_stage #(
        .AW (IW),
        .BW (QW)
    ) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (t_valid),
        .i_l     (t_q),
        .i_r     (r_q2_s2),
        .o_valid (m2_valid),
        .o_prod  (m2_prod)
    );

    qvr_sum_stage #(
        .PW (PW2),
        .QF (QUAT_FRAC_BITS),
        .OW (CW)
    ) u_sum2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_valid),
        .i_prod  (m2_prod),
        .o_valid (f_valid),
        .o_q     (f_q),
        .o_clip  (f_clip)
    );

    assign o_valid          = f_valid;
    assign o_result.out_x   = f_q[0];
    assign o_result.out_y   = f_q[1];
    assign o_result.out_z   = f_q[2];
    assign o_result.out_w   = f_q[3];
    assign o_result.clipped = f_clip || r_clip_s4;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted transaction produced no result after five cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result strobe without a matching transaction");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside the cycle after reset");
`endif

endmodule

`default_nettype wire
